FILE: hw/rtl/b64c_pkg.sv
// Shared types, constants and character mapping functions of the base64 codec.
package b64c_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] CH_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;

    localparam logic [7:0] UP_OFFSET = 8'd65;
    localparam logic [7:0] LO_OFFSET = 8'd71;
    localparam logic [7:0] DIG_SHIFT = 8'd4;

    localparam logic [5:0] IDX_PLUS  = 6'd62;
    localparam logic [5:0] IDX_SLASH = 6'd63;

    typedef enum logic [1:0] {
        JOB_ENC,
        JOB_DEC,
        JOB_ERR
    } t_job_kind;

    // One finished group, handed from the front end to the output sequencer.
    typedef struct packed {
        t_job_kind   kind;
        logic [23:0] bits;
        logic [1:0]  last_idx;   // index of the final result of the group
        logic [2:0]  enc_chars;  // alphabet characters before padding (encode)
    } t_job;

    typedef struct packed {
        logic       bad;
        logic       pad;
        logic [5:0] idx;
    } t_char_class;

    // Maps a 6-bit index to its alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] idx);
        logic [7:0] wide;
        wide = {2'b00, idx};
        if (idx < 6'd26) begin
            enc_char = wide + UP_OFFSET;
        end else if (idx < 6'd52) begin
            enc_char = wide + LO_OFFSET;
        end else if (idx < IDX_PLUS) begin
            enc_char = wide - DIG_SHIFT;
        end else if (idx == IDX_PLUS) begin
            enc_char = CH_PLUS;
        end else begin
            enc_char = CH_SLASH;
        end
    endfunction

    // Classifies a received character as an index, padding or invalid.
    function automatic t_char_class classify(input logic [7:0] c);
        t_char_class r;
        logic [7:0]  t;
        r = '{bad: 1'b0, pad: 1'b0, idx: 6'd0};
        t = 8'd0;
        if (c == CH_PAD) begin
            r.pad = 1'b1;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            t     = c - UP_OFFSET;
            r.idx = t[5:0];
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            t     = c - LO_OFFSET;
            r.idx = t[5:0];
        end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            t     = c + DIG_SHIFT;
            r.idx = t[5:0];
        end else if (c == CH_PLUS) begin
            r.idx = IDX_PLUS;
        end else if (c == CH_SLASH) begin
            r.idx = IDX_SLASH;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/base64_stream_codec.sv
// Top level of the streaming base64 encoder and decoder.
//
//  Channel | Dir | Beat contents
//  --------+-----+-------------------------------------------------------------
//  s_axis  | in  | tdata[7:0] raw byte or character code, tlast end of message
//  m_axis  | out | tdata[7:0] character or byte, tlast final result of the group,
//          |     | tuser invalid character seen
//  cfg     | in  | wdata mode: 0 encode, 1 decode
//
// An input beat is taken in every cycle while the job queue has room; the front
// end turns it into state updates in that cycle and posts a job when a group is
// complete. The output sequencer sends one result beat per cycle while the output
// is not stalled, so a full encode group gives four output beats for three input
// beats, and the output port sets the sustained rate.
// Reset is synchronous and active low; it selects encode mode and empties the
// group, the queue and the output register. A stall on the output fills the
// queue and then removes the input ready; a stalled input leaves the queue to
// drain. A write to the mode register also empties the group being collected.
module base64_stream_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,
    output logic       o_m_axis_tuser    // [0] bad_character
);
    import b64c_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_job job_in;
    t_job job_out;

    // Front end: mode register, group collection and character classification.
    b64c_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_eom       (i_s_axis_tlast),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (job_in)
    );

    // Finished groups wait here so that each side can stall on its own.
    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (job_out)
    );

    // Back end: one result beat per cycle while the output is not stalled, into a registered output stage.
    b64c_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (job_out),
        .o_pop     (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast),
        .o_bad     (o_m_axis_tuser)
    );

    // An error beat is always the single, zero-valued result of its input beat.
    a_err_beat_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tlast && o_m_axis_tdata == 8'd0))
        else $error("error beat is not a lone zero beat");

endmodule

FILE: hw/rtl/b64c_front.sv
// Front end: accepts beats, gathers groups and posts finished groups as jobs.
module b64c_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_eom,
    input  logic              i_q_full,
    output logic              o_push,
    output b64c_pkg::t_job    o_job
);
    import b64c_pkg::*;

    logic        r_mode;
    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_cnt, n_cnt;
    logic [2:0]  r_pad, n_pad;
    logic        r_err, n_err;
    logic        accept;
    t_char_class cc;
    logic [5:0]  sextet;
    logic [1:0]  cnt_inc;
    logic [2:0]  pad_inc;
    logic [23:0] bits_ins;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign cc      = classify(i_byte);
    assign sextet  = cc.pad ? 6'd0 : cc.idx;
    assign cnt_inc = r_cnt + 2'd1;
    assign pad_inc = r_pad + {2'b00, cc.pad};

    always_comb begin
        bits_ins = r_bits;
        if (r_mode == MODE_ENCODE) begin
            unique case (r_cnt)
                2'd0:    bits_ins[23:16] = r_bits[23:16] | i_byte;
                2'd1:    bits_ins[15:8]  = r_bits[15:8]  | i_byte;
                default: bits_ins[7:0]   = r_bits[7:0]   | i_byte;
            endcase
        end else begin
            unique case (r_cnt)
                2'd0:    bits_ins[23:18] = r_bits[23:18] | sextet;
                2'd1:    bits_ins[17:12] = r_bits[17:12] | sextet;
                2'd2:    bits_ins[11:6]  = r_bits[11:6]  | sextet;
                default: bits_ins[5:0]   = r_bits[5:0]   | sextet;
            endcase
        end
    end

    always_comb begin
        n_bits = r_bits;
        n_cnt  = r_cnt;
        n_pad  = r_pad;
        n_err  = r_err;
        o_push = 1'b0;
        o_job  = '{kind: JOB_ENC, bits: bits_ins, last_idx: 2'd3,
                   enc_chars: {1'b0, cnt_inc} + 3'd1};
        if (accept) begin
            if (r_mode == MODE_ENCODE) begin
                n_bits = bits_ins;
                n_cnt  = cnt_inc;
                if (cnt_inc == 2'd3 || i_eom) begin
                    o_push = 1'b1;
                    n_bits = '0;
                    n_cnt  = '0;
                    n_pad  = '0;
                end
            end else if (r_err) begin
                // Dropping beats until the end of the message.
                if (i_eom) begin
                    n_err = 1'b0;
                end
            end else if (cc.bad) begin
                o_push         = 1'b1;
                o_job.kind     = JOB_ERR;
                o_job.last_idx = 2'd0;
                n_bits = '0;
                n_cnt  = '0;
                n_pad  = '0;
                n_err  = !i_eom;
            end else begin
                n_bits = bits_ins;
                n_cnt  = cnt_inc;
                n_pad  = pad_inc;
                if (cnt_inc == 2'd0 || i_eom) begin
                    o_job.kind = JOB_DEC;
                    // Three bytes less the padding; nothing once padding reaches three.
                    o_push         = (pad_inc < 3'd3);
                    o_job.last_idx = 2'd2 - pad_inc[1:0];
                    n_bits = '0;
                    n_cnt  = '0;
                    n_pad  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
            r_bits <= '0;
            r_cnt  <= '0;
            r_pad  <= '0;
            r_err  <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
            r_bits <= '0;
            r_cnt  <= '0;
            r_pad  <= '0;
            r_err  <= 1'b0;
        end else begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
            r_pad  <= n_pad;
            r_err  <= n_err;
        end
    end

    a_err_only_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (r_mode == MODE_DECODE))
        else $error("error latch set outside decode mode");

endmodule

FILE: hw/rtl/b64c_queue.sv
// Short job queue between the front end and the output sequencer.
module b64c_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64c_pkg::t_job    i_job,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output b64c_pkg::t_job    o_job
);
    import b64c_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");

endmodule

FILE: hw/rtl/b64c_back.sv
// Output sequencer: turns each queued job into one to four result beats.
module b64c_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  b64c_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_data,
    output logic              o_last,
    output logic              o_bad
);
    import b64c_pkg::*;

    logic       r_valid;
    logic [7:0] r_data, n_data;
    logic       r_last;
    logic       r_bad;
    logic [1:0] r_k;
    logic       load;
    logic       final_beat;
    logic [5:0] sextet;
    logic [7:0] dec_byte;

    assign load       = !r_valid || i_ready;
    assign final_beat = (r_k == i_job.last_idx);
    assign o_pop      = load && i_q_valid && final_beat;

    always_comb begin
        unique case (r_k)
            2'd0:    sextet = i_job.bits[23:18];
            2'd1:    sextet = i_job.bits[17:12];
            2'd2:    sextet = i_job.bits[11:6];
            default: sextet = i_job.bits[5:0];
        endcase
        unique case (r_k)
            2'd0:    dec_byte = i_job.bits[23:16];
            2'd1:    dec_byte = i_job.bits[15:8];
            default: dec_byte = i_job.bits[7:0];
        endcase
    end

    always_comb begin
        unique case (i_job.kind)
            JOB_ENC: n_data = ({1'b0, r_k} < i_job.enc_chars) ? enc_char(sextet) : CH_PAD;
            JOB_DEC: n_data = dec_byte;
            default: n_data = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_k <= final_beat ? 2'd0 : r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_data <= n_data;
            r_last <= final_beat;
            r_bad  <= (i_job.kind == JOB_ERR);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_bad   = r_bad;

    a_pop_shows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_last))
        else $error("job retired without presenting its final beat");

endmodule
